### rtl/core/progression_line_sieve_unit_defines.svh
// ---------------------------------------------------------------------------
// progression line sieve: assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef PROGRESSION_LINE_SIEVE_UNIT_DEFINES_SVH
`define PROGRESSION_LINE_SIEVE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define PLSV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PLSV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PLSV_ASSERT_IMP(lbl, ante, cons, msg)
`define PLSV_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/plsv_pkg.sv
// ---------------------------------------------------------------------------
// plsv_pkg
// shared widths, beat kinds and the control struct that rides the cell chain
// ---------------------------------------------------------------------------
`default_nettype none
package plsv_pkg;

	localparam int IDX_W    = 10;
	localparam int WEIGHT_W = 16;
	localparam int CNT_W    = 11;

	// beat kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// control part of a chain token; data is weight on load, cut on start,
	// running score on tick
	typedef struct packed {
		logic                valid;
		logic [1:0]          kind;
		logic                adv;
		logic [IDX_W-1:0]    idx;
		logic [WEIGHT_W-1:0] data;
	} tok_ctl_t;

	// remainder unit status
	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage
`default_nettype wire

### rtl/core/plsv_mod.sv
// ---------------------------------------------------------------------------
// plsv_mod
// bit-serial restoring remainder of start and root by the effective step,
// one bit per cycle, holds the load beat until taken
// ---------------------------------------------------------------------------
`default_nettype none
module plsv_mod import plsv_pkg::*; #(
	parameter int STEP_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic [IDX_W-1:0]     idx_in,
	input  wire logic [STEP_BITS-1:0] step_in,
	input  wire logic [STEP_BITS-1:0] start_in,
	input  wire logic [STEP_BITS-1:0] root_in,
	input  wire logic [WEIGHT_W-1:0]  weight_in,
	input  wire logic                 take,
	output mod_stat_t                 stat,
	output logic [IDX_W-1:0]          idx_out,
	output logic [STEP_BITS-1:0]      step_out,
	output logic [STEP_BITS-1:0]      start_out,
	output logic [STEP_BITS-1:0]      start_red_out,
	output logic [STEP_BITS-1:0]      root_red_out,
	output logic [WEIGHT_W-1:0]       weight_out
);

	localparam int CNTB = $clog2(STEP_BITS + 1);

	logic                 busy_q;
	logic [CNTB-1:0]      cnt_q;
	logic [STEP_BITS-1:0] div_q;
	logic [STEP_BITS-1:0] sx_q;
	logic [STEP_BITS-1:0] rx_q;
	logic [STEP_BITS-1:0] srem_q;
	logic [STEP_BITS-1:0] rrem_q;
	logic [IDX_W-1:0]     idx_q;
	logic [STEP_BITS-1:0] step_q;
	logic [STEP_BITS-1:0] start_q;
	logic [WEIGHT_W-1:0]  weight_q;
	logic                 done;

	function automatic logic [STEP_BITS-1:0] rem_step(
		input logic [STEP_BITS-1:0] rem,
		input logic                 nbit,
		input logic [STEP_BITS-1:0] dv
	);
		logic [STEP_BITS:0] trial;
		logic [STEP_BITS:0] diff;
		trial = {rem, nbit};
		diff  = trial - {1'b0, dv};
		return (trial >= {1'b0, dv}) ? diff[STEP_BITS-1:0] : trial[STEP_BITS-1:0];
	endfunction

	assign done = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTB'(STEP_BITS);
		end else if (done && take) begin
			busy_q <= 1'b0;
		end else if (busy_q && !done) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			// a zero step acts as a step of one
			div_q    <= (step_in == '0) ? STEP_BITS'(1) : step_in;
			sx_q     <= start_in;
			rx_q     <= root_in;
			srem_q   <= '0;
			rrem_q   <= '0;
			idx_q    <= idx_in;
			step_q   <= step_in;
			start_q  <= start_in;
			weight_q <= weight_in;
		end else if (busy_q && !done) begin
			srem_q <= rem_step(srem_q, sx_q[STEP_BITS-1], div_q);
			rrem_q <= rem_step(rrem_q, rx_q[STEP_BITS-1], div_q);
			sx_q   <= sx_q << 1;
			rx_q   <= rx_q << 1;
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done;
	assign idx_out       = idx_q;
	assign step_out      = step_q;
	assign start_out     = start_q;
	assign start_red_out = srem_q;
	assign root_red_out  = rrem_q;
	assign weight_out    = weight_q;

endmodule
`default_nettype wire

### rtl/core/plsv_cell.sv
// ---------------------------------------------------------------------------
// plsv_cell
// one progression slot: holds its entry and countdown, acts on the token
// passing through and, unless the chain is stalled, hands it on one cell per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module plsv_cell import plsv_pkg::*; #(
	parameter int STEP_BITS  = 8,
	parameter int CELL_INDEX = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 shift_en,
	input  wire logic [CNT_W-1:0]     entries_in_use,
	input  wire tok_ctl_t             ctl_in,
	input  wire logic [STEP_BITS-1:0] step_in,
	input  wire logic [STEP_BITS-1:0] start_in,
	input  wire logic [STEP_BITS-1:0] start_red_in,
	input  wire logic [STEP_BITS-1:0] root_red_in,
	output tok_ctl_t                  ctl_out,
	output logic [STEP_BITS-1:0]      step_out,
	output logic [STEP_BITS-1:0]      start_out,
	output logic [STEP_BITS-1:0]      start_red_out,
	output logic [STEP_BITS-1:0]      root_red_out
);

	tok_ctl_t             ctl_q;
	tok_ctl_t             ctl_nxt;
	logic [STEP_BITS-1:0] step_pass_q;
	logic [STEP_BITS-1:0] start_pass_q;
	logic [STEP_BITS-1:0] sred_pass_q;
	logic [STEP_BITS-1:0] rred_pass_q;

	// entry storage
	logic [STEP_BITS-1:0] step_q;
	logic [STEP_BITS-1:0] start_q;
	logic [STEP_BITS-1:0] start_red_q;
	logic [STEP_BITS-1:0] root_q;
	logic [WEIGHT_W-1:0]  weight_q;
	logic [STEP_BITS-1:0] cd_q;

	logic                 active;
	logic                 do_load;
	logic                 do_start;
	logic                 do_tick;
	logic [STEP_BITS-1:0] step_eff;
	logic [STEP_BITS:0]   wrap_sum;
	logic [STEP_BITS-1:0] new_start;
	logic [WEIGHT_W:0]    acc_sum;

	assign active   = 32'(entries_in_use) > CELL_INDEX;
	assign do_load  = ctl_in.valid && (ctl_in.kind == KIND_LOAD)
	                  && (32'(ctl_in.idx) == CELL_INDEX);
	assign do_start = ctl_in.valid && (ctl_in.kind == KIND_START) && active;
	assign do_tick  = ctl_in.valid && (ctl_in.kind == KIND_TICK) && active;

	assign step_eff  = (step_q == '0) ? STEP_BITS'(1) : step_q;
	assign wrap_sum  = {1'b0, start_red_q} + {1'b0, step_eff} - {1'b0, root_q};
	assign new_start = (start_red_q >= root_q) ? (start_red_q - root_q)
	                                           : wrap_sum[STEP_BITS-1:0];
	assign acc_sum   = {1'b0, ctl_in.data} + {1'b0, weight_q};

	always_comb begin
		ctl_nxt = ctl_in;
		if (do_tick && (cd_q == '0)) begin
			// saturate at full scale
			ctl_nxt.data = acc_sum[WEIGHT_W] ? '1 : acc_sum[WEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
			cd_q  <= '0;
		end else if (shift_en) begin
			ctl_q <= ctl_nxt;
			if (do_load) begin
				cd_q <= start_in;
			end else if (do_start) begin
				cd_q <= ctl_in.adv ? new_start : start_q;
			end else if (do_tick) begin
				cd_q <= (cd_q == '0) ? (step_eff - 1'b1) : (cd_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			step_pass_q  <= step_in;
			start_pass_q <= start_in;
			sred_pass_q  <= start_red_in;
			rred_pass_q  <= root_red_in;
			if (do_load) begin
				step_q      <= step_in;
				start_q     <= start_in;
				start_red_q <= start_red_in;
				root_q      <= root_red_in;
				weight_q    <= ctl_in.data;
			end else if (do_start && ctl_in.adv) begin
				start_q     <= new_start;
				start_red_q <= new_start;
			end
		end
	end

	assign ctl_out       = ctl_q;
	assign step_out      = step_pass_q;
	assign start_out     = start_pass_q;
	assign start_red_out = sred_pass_q;
	assign root_red_out  = rred_pass_q;

endmodule
`default_nettype wire

### rtl/core/progression_line_sieve_unit.sv
// ---------------------------------------------------------------------------
// progression_line_sieve_unit
// line sieve over a table of arithmetic progressions, one cell per entry
// ---------------------------------------------------------------------------
// Every table entry lives in its own cell of a chain of MAX_PROGRESSIONS
// cells; each start, tick or load beat becomes a token that walks the chain
// one cell per cycle while it is not stalled, so every cell sees beats in
// order; an active cell updates its countdown as a tick passes and adds its
// weight into the running score when the countdown is zero. Start-line and
// sieve-tick beats are taken one per cycle unless the chain stalls or a load
// is held; a load beat first runs through a bit-serial remainder unit (start
// and root modulo the step) and holds the input off until it is handed on.
// The whole chain advances together, so a stalled output stalls the chain
// and the input. The user must make configuration writes only after the
// chain has drained; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none
`include "progression_line_sieve_unit_defines.svh"
module progression_line_sieve_unit import plsv_pkg::*; #(
	parameter int MAX_PROGRESSIONS = 1024,
	parameter int STEP_BITS        = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [21:0] cfg_data,
	// input beats
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [9:0]  entry_index,
	input  wire logic [7:0]  step_size,
	input  wire logic [7:0]  start_offset,
	input  wire logic [7:0]  root_shift,
	input  wire logic [15:0] weight,
	input  wire logic [15:0] cut,
	input  wire logic        advance,
	// result beats
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [20:0]      position,
	output logic [15:0]      score,
	output logic             hit,
	output logic             line_end
);

	// register indexes
	localparam logic CFG_ENTRIES = 1'b0;
	localparam logic CFG_LENGTH  = 1'b1;

	localparam logic [21:0] LINE_MAX     = 22'd2097152;
	localparam logic [21:0] LENGTH_RESET = 22'd8192;

	// configuration registers
	logic [CNT_W-1:0] entries_q;
	logic [21:0]      length_q;

	// chain links: index 0 is the injection register, the last is the tail
	tok_ctl_t             link_ctl   [MAX_PROGRESSIONS+1];
	logic [STEP_BITS-1:0] link_step  [MAX_PROGRESSIONS+1];
	logic [STEP_BITS-1:0] link_start [MAX_PROGRESSIONS+1];
	logic [STEP_BITS-1:0] link_sred  [MAX_PROGRESSIONS+1];
	logic [STEP_BITS-1:0] link_rred  [MAX_PROGRESSIONS+1];

	// injection register
	tok_ctl_t             inj_ctl_q;
	tok_ctl_t             inj_ctl_nxt;
	logic [STEP_BITS-1:0] inj_step_q;
	logic [STEP_BITS-1:0] inj_start_q;
	logic [STEP_BITS-1:0] inj_sred_q;
	logic [STEP_BITS-1:0] inj_rred_q;

	// remainder unit
	mod_stat_t            mod_stat;
	logic                 mod_go;
	logic                 mod_take;
	logic [IDX_W-1:0]     mod_idx;
	logic [STEP_BITS-1:0] mod_step;
	logic [STEP_BITS-1:0] mod_start;
	logic [STEP_BITS-1:0] mod_sred;
	logic [STEP_BITS-1:0] mod_rred;
	logic [WEIGHT_W-1:0]  mod_weight;

	// tail side: line state and output register
	tok_ctl_t    tail;
	logic [15:0] cut_q;
	logic [20:0] pos_q;
	logic [21:0] len_eff;
	logic [20:0] pos_cur;
	logic        pos_last;
	logic        out_valid_q;
	logic [20:0] position_q;
	logic [15:0] score_q;
	logic        hit_q;
	logic        line_end_q;

	logic shift_en;
	logic in_acc;

	// the chain moves whenever the output register is free or being drained
	assign shift_en = !out_valid_q || out_ready;
	assign in_ready = shift_en && !mod_stat.busy;
	assign in_acc   = in_valid && in_ready;
	assign mod_go   = in_acc && (kind == KIND_LOAD);
	assign mod_take = mod_stat.done && shift_en;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
			length_q  <= LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENTRIES: entries_q <= cfg_data[CNT_W-1:0];
				CFG_LENGTH:  length_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	plsv_mod #(
		.STEP_BITS(STEP_BITS)
	) u_mod (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (mod_go),
		.idx_in       (entry_index),
		.step_in      (STEP_BITS'(step_size)),
		.start_in     (STEP_BITS'(start_offset)),
		.root_in      (STEP_BITS'(root_shift)),
		.weight_in    (weight),
		.take         (mod_take),
		.stat         (mod_stat),
		.idx_out      (mod_idx),
		.step_out     (mod_step),
		.start_out    (mod_start),
		.start_red_out(mod_sred),
		.root_red_out (mod_rred),
		.weight_out   (mod_weight)
	);

	// build the token for the chain head
	always_comb begin
		inj_ctl_nxt = '0;
		if (mod_take) begin
			inj_ctl_nxt.valid = 1'b1;
			inj_ctl_nxt.kind  = KIND_LOAD;
			inj_ctl_nxt.idx   = mod_idx;
			inj_ctl_nxt.data  = mod_weight;
		end else if (in_acc && (kind == KIND_START)) begin
			inj_ctl_nxt.valid = 1'b1;
			inj_ctl_nxt.kind  = KIND_START;
			inj_ctl_nxt.adv   = advance;
			// a zero cut is kept as one
			inj_ctl_nxt.data  = (cut == '0) ? 16'd1 : cut;
		end else if (in_acc && (kind == KIND_TICK)) begin
			inj_ctl_nxt.valid = 1'b1;
			inj_ctl_nxt.kind  = KIND_TICK;
		end
		// unknown kind: taken and dropped
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_ctl_q <= '0;
		end else if (shift_en) begin
			inj_ctl_q <= inj_ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			inj_step_q  <= mod_step;
			inj_start_q <= mod_start;
			inj_sred_q  <= mod_sred;
			inj_rred_q  <= mod_rred;
		end
	end

	assign link_ctl[0]   = inj_ctl_q;
	assign link_step[0]  = inj_step_q;
	assign link_start[0] = inj_start_q;
	assign link_sred[0]  = inj_sred_q;
	assign link_rred[0]  = inj_rred_q;

	// the cell chain
	for (genvar g = 0; g < MAX_PROGRESSIONS; g++) begin : g_cell
		plsv_cell #(
			.STEP_BITS (STEP_BITS),
			.CELL_INDEX(g)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.shift_en      (shift_en),
			.entries_in_use(entries_q),
			.ctl_in        (link_ctl[g]),
			.step_in       (link_step[g]),
			.start_in      (link_start[g]),
			.start_red_in  (link_sred[g]),
			.root_red_in   (link_rred[g]),
			.ctl_out       (link_ctl[g+1]),
			.step_out      (link_step[g+1]),
			.start_out     (link_start[g+1]),
			.start_red_out (link_sred[g+1]),
			.root_red_out  (link_rred[g+1])
		);
	end

	assign tail = link_ctl[MAX_PROGRESSIONS];

	// effective line length: zero acts as one, clipped at the line maximum
	assign len_eff  = (length_q == '0) ? 22'd1 :
	                  ((length_q > LINE_MAX) ? LINE_MAX : length_q);
	// ticks past the end wrap to position zero
	assign pos_cur  = ({1'b0, pos_q} >= len_eff) ? '0 : pos_q;
	assign pos_last = ({1'b0, pos_cur} == (len_eff - 22'd1));

	// tail: line state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q       <= 16'd1;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (shift_en) begin
			out_valid_q <= tail.valid && (tail.kind == KIND_TICK);
			if (tail.valid && (tail.kind == KIND_START)) begin
				cut_q <= tail.data;
				pos_q <= '0;
			end else if (tail.valid && (tail.kind == KIND_TICK)) begin
				pos_q <= pos_last ? '0 : (pos_cur + 21'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en && tail.valid && (tail.kind == KIND_TICK)) begin
			position_q <= pos_cur;
			score_q    <= tail.data;
			hit_q      <= tail.data >= cut_q;
			line_end_q <= pos_last;
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign score     = score_q;
	assign hit       = hit_q;
	assign line_end  = line_end_q;

	// no beat is taken while the remainder unit holds a load
	`PLSV_ASSERT_IMP(a_load_blocks_input, mod_stat.busy, !in_ready, "input taken during load")
	// a stalled output freezes the chain head
	`PLSV_ASSERT_NXT(a_stall_freezes, out_valid && !out_ready, inj_ctl_q == $past(inj_ctl_q), "chain moved while stalled")
	// the cut is never zero, so a hit needs a nonzero score
	`PLSV_ASSERT_IMP(a_hit_needs_score, out_valid && hit, score != '0, "hit with zero score")
	// the line end sits on the last position of the line
	`PLSV_ASSERT_IMP(a_line_end_pos, out_valid && line_end, ({1'b0, position} == (len_eff - 22'd1)), "line end off last position")

endmodule
`default_nettype wire

### tb/sv/progression_line_sieve_unit_tb.sv
// ---------------------------------------------------------------------------
// progression_line_sieve_unit_tb
// self-checking bench: random and directed beats against a built-in predictor
// ---------------------------------------------------------------------------
// A queue of pending input beats feeds a clocked driver. Each accepted beat
// runs through a predictor that keeps its own copy of the progression table,
// the countdowns, the line state and both registers. Every sieve tick pushes
// one predicted result. A clocked monitor compares every result beat, field by
// field, with the oldest prediction. The run is split into phases: each phase
// waits for the block to drain, rewrites both registers and then queues a mix
// of well-formed lines, tick runs, reloads, ignored beats and bare starts,
// under its own sender and receiver idle rates.
// ---------------------------------------------------------------------------
`default_nettype none
module progression_line_sieve_unit_tb;
	import plsv_pkg::*;

	localparam int NUM_PROG = 1024;
	localparam int STEP_W   = 8;
	localparam int LINE_CAP = 2097152;
	// chain depth plus the serial remainder unit plus some margin
	localparam int DRAIN    = NUM_PROG + STEP_W + 20;
	localparam int HOLD_LEN = 2500;

	// register indexes and the unused beat kind
	localparam logic REG_ENTRIES  = 1'b0;
	localparam logic REG_LINE_LEN = 1'b1;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  entry_index;
		logic [7:0]  step_size;
		logic [7:0]  start_offset;
		logic [7:0]  root_shift;
		logic [15:0] weight;
		logic [15:0] cut;
		logic        advance;
	} sieve_beat_t;

	localparam int BEAT_W = $bits(sieve_beat_t);

	typedef struct packed {
		logic [20:0] position;
		logic [15:0] score;
		logic        hit;
		logic        line_end;
	} score_beat_t;

	// dut signals; the inputs are all known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_ENTRIES;
	logic [21:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = KIND_UNUSED;
	logic [9:0]  entry_index = '0;
	logic [7:0]  step_size = '0;
	logic [7:0]  start_offset = '0;
	logic [7:0]  root_shift = '0;
	logic [15:0] weight = '0;
	logic [15:0] cut = '0;
	logic        advance = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [20:0] position;
	logic [15:0] score;
	logic        hit;
	logic        line_end;

	// beats waiting to be offered, and results still owed by the block
	sieve_beat_t queued_beats[$];
	score_beat_t predicted_scores[$];
	sieve_beat_t cur_beat;
	int unsigned beats_queued = 0;
	int unsigned beats_taken = 0;
	int unsigned error_count = 0;

	// idle rates in percent, changed only between phases
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// long receiver hold-off requests, served by the monitor
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;

	// predictor state
	logic [7:0]  tbl_step   [NUM_PROG];
	logic [7:0]  tbl_start  [NUM_PROG];
	logic [7:0]  tbl_root   [NUM_PROG];
	logic [15:0] tbl_weight [NUM_PROG];
	logic [7:0]  tbl_count  [NUM_PROG];
	int unsigned cur_cut = 1;
	int unsigned cur_pos = 0;
	logic [10:0] cfg_entries = 11'd0;
	logic [21:0] cfg_length = 22'd8192;

	// slots that have been loaded at least once, so no active slot is read unset
	bit loaded [NUM_PROG];

	progression_line_sieve_unit #(
		.MAX_PROGRESSIONS(NUM_PROG),
		.STEP_BITS(STEP_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.entry_index(entry_index),
		.step_size(step_size),
		.start_offset(start_offset),
		.root_shift(root_shift),
		.weight(weight),
		.cut(cut),
		.advance(advance),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position(position),
		.score(score),
		.hit(hit),
		.line_end(line_end)
	);

	always #5 clk = ~clk;

	// a step of zero counts as one
	function automatic int unsigned step_of(input logic [7:0] s);
		return (s == 8'd0) ? 1 : int'(s);
	endfunction

	// advance the table by one accepted beat and record the result it owes
	task automatic sieve_predict(input sieve_beat_t b);
		int unsigned n, s, st, rt, len, pos, total;
		score_beat_t r;
		n = (cfg_entries > NUM_PROG) ? NUM_PROG : cfg_entries;
		case (b.kind)
			KIND_LOAD: begin
				tbl_step[b.entry_index]   = b.step_size;
				tbl_start[b.entry_index]  = b.start_offset;
				tbl_root[b.entry_index]   = b.root_shift;
				tbl_weight[b.entry_index] = b.weight;
				// a load arms the countdown right away
				tbl_count[b.entry_index]  = b.start_offset;
			end
			KIND_START: begin
				cur_cut = (b.cut == 16'd0) ? 1 : b.cut;
				cur_pos = 0;
				for (int i = 0; i < n; i++) begin
					if (b.advance) begin
						// move the start back by the root, both reduced mod step
						s  = step_of(tbl_step[i]);
						st = tbl_start[i] % s;
						rt = tbl_root[i] % s;
						tbl_start[i] = 8'((st + s - rt) % s);
					end
					tbl_count[i] = tbl_start[i];
				end
			end
			KIND_TICK: begin
				if (cfg_length == 22'd0)
					len = 1;
				else if (cfg_length > LINE_CAP)
					len = LINE_CAP;
				else
					len = 32'(cfg_length);
				pos = (cur_pos >= len) ? 0 : cur_pos;
				total = 0;
				for (int i = 0; i < n; i++) begin
					if (tbl_count[i] == 8'd0) begin
						total += tbl_weight[i];
						if (total > 16'hFFFF)
							total = 16'hFFFF;
						tbl_count[i] = 8'(step_of(tbl_step[i]) - 1);
					end else begin
						tbl_count[i] = tbl_count[i] - 8'd1;
					end
				end
				r.position = 21'(pos);
				r.score    = 16'(total);
				r.hit      = (total >= cur_cut);
				r.line_end = (pos == len - 1);
				predicted_scores.push_back(r);
				cur_pos = r.line_end ? 0 : pos + 1;
			end
			default: ;
		endcase
	endtask

	// driver: offers the next queued beat once the current one is taken
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			sieve_predict(cur_beat);
			beats_taken++;
		end
		if (!in_valid || in_ready) begin
			if (arst_n && queued_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				cur_beat = queued_beats.pop_front();
				in_valid     <= 1'b1;
				kind         <= cur_beat.kind;
				entry_index  <= cur_beat.entry_index;
				step_size    <= cur_beat.step_size;
				start_offset <= cur_beat.start_offset;
				root_shift   <= cur_beat.root_shift;
				weight       <= cur_beat.weight;
				cut          <= cur_beat.cut;
				advance      <= cur_beat.advance;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each result beat and drives the receiver's ready
	always @(posedge clk) begin
		score_beat_t want;
		if (out_valid && out_ready) begin
			if (predicted_scores.size() == 0) begin
				$error("unexpected result beat: position %0d score %0d", position, score);
				error_count++;
			end else begin
				want = predicted_scores.pop_front();
				if (position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, position);
					error_count++;
				end
				if (score !== want.score) begin
					$error("score: expected %0d, got %0d", want.score, score);
					error_count++;
				end
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					error_count++;
				end
				if (line_end !== want.line_end) begin
					$error("line_end: expected %0d, got %0d", want.line_end, line_end);
					error_count++;
				end
			end
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			// long hold-off in progress: let the chain back up into the input
			hold_left--;
			out_ready <= 1'b0;
		end else if (holds_done != holds_asked) begin
			holds_done++;
			hold_left = HOLD_LEN;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// every field random, so unused fields toggle too
	function automatic sieve_beat_t random_beat();
		logic [BEAT_W-1:0] raw;
		raw = BEAT_W'({$urandom(), $urandom(), $urandom()});
		return raw;
	endfunction

	function automatic logic [15:0] random_cut();
		int r;
		r = $urandom_range(9, 0);
		if (r == 0)
			return 16'd0;
		else if (r == 1)
			return 16'hFFFF;
		else if (r == 2)
			return 16'($urandom());
		return 16'($urandom_range(600, 1));
	endfunction

	task automatic push_beat(input sieve_beat_t b);
		queued_beats.push_back(b);
		beats_queued++;
	endtask

	task automatic push_load(input int slot, input logic [7:0] st_sz, input logic [7:0] st_off,
		input logic [7:0] rt, input logic [15:0] wt);
		sieve_beat_t b;
		b = random_beat();
		b.kind         = KIND_LOAD;
		b.entry_index  = 10'(slot);
		b.step_size    = st_sz;
		b.start_offset = st_off;
		b.root_shift   = rt;
		b.weight       = wt;
		loaded[slot]   = 1'b1;
		push_beat(b);
	endtask

	// mostly short steps so hits are frequent, starts and roots mostly below step
	task automatic push_random_load(input int slot);
		int r;
		logic [7:0] st_sz, st_off, rt;
		logic [15:0] wt;
		r = $urandom_range(99, 0);
		if (r < 75)
			st_sz = 8'($urandom_range(16, 1));
		else if (r < 90)
			st_sz = 8'($urandom_range(199, 17));
		else
			st_sz = 8'($urandom());
		st_off = ($urandom_range(99, 0) < 85) ?
			8'($urandom_range((st_sz == 0) ? 0 : st_sz - 1, 0)) : 8'($urandom());
		rt = ($urandom_range(99, 0) < 85) ?
			8'($urandom_range((st_sz == 0) ? 0 : st_sz - 1, 0)) : 8'($urandom());
		r = $urandom_range(99, 0);
		if (r < 80)
			wt = 16'($urandom_range(300, 1));
		else if (r < 85)
			wt = 16'd0;
		else if (r < 90)
			wt = 16'hFFFF;
		else
			wt = 16'($urandom());
		push_load(slot, st_sz, st_off, rt, wt);
	endtask

	task automatic push_start(input logic [15:0] c, input logic adv);
		sieve_beat_t b;
		b = random_beat();
		b.kind    = KIND_START;
		b.cut     = c;
		b.advance = adv;
		push_beat(b);
	endtask

	task automatic push_tick();
		sieve_beat_t b;
		b = random_beat();
		b.kind = KIND_TICK;
		push_beat(b);
	endtask

	task automatic push_ignored();
		sieve_beat_t b;
		b = random_beat();
		b.kind = KIND_UNUSED;
		push_beat(b);
	endtask

	// all beats taken, all results back, then let the chain empty out
	task automatic wait_idle();
		while (beats_taken != beats_queued)
			@(posedge clk);
		while (predicted_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 22'(val);
		if (idx == REG_ENTRIES)
			cfg_entries = 11'(val);
		else
			cfg_length = 22'(val);
	endtask

	task automatic set_config(input int unsigned n_cfg, input int unsigned len_cfg,
		input int send_pct, input int stall_pct);
		wait_idle();
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		write_reg(REG_ENTRIES, n_cfg);
		write_reg(REG_LINE_LEN, len_cfg);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one random phase: fill any unloaded active slot first, then the mix
	task automatic run_phase(input int unsigned n_cfg, input int unsigned len_cfg,
		input int send_pct, input int stall_pct, input int count, input bit long_hold);
		int n_act, len_eff, made, r, k, slot;
		set_config(n_cfg, len_cfg, send_pct, stall_pct);
		n_act = (n_cfg > NUM_PROG) ? NUM_PROG : n_cfg;
		if (len_cfg == 0)
			len_eff = 1;
		else
			len_eff = (len_cfg > LINE_CAP) ? LINE_CAP : len_cfg;
		for (int i = 0; i < n_act; i++)
			if (!loaded[i])
				push_random_load(i);
		made = 0;
		if (long_hold) begin
			holds_asked++;
			// the first result sits in the output under the hold while the loads
			// for the rest of the table back up behind it
			push_start(random_cut(), 1'b0);
			push_tick();
			made += 2;
			for (int i = n_act; i < NUM_PROG; i++)
				if (!loaded[i])
					push_random_load(i);
		end
		while (made < count) begin
			r = $urandom_range(99, 0);
			if (r < 55) begin
				// a start-line beat and a run of ticks, on short lines sometimes a few past the end
				push_start(random_cut(), 1'($urandom_range(1, 0)));
				k = (len_eff <= 64) ? $urandom_range(len_eff + 3, 1) : $urandom_range(40, 1);
				repeat (k) push_tick();
				made += k + 1;
			end else if (r < 70) begin
				k = $urandom_range(6, 1);
				repeat (k) push_tick();
				made += k;
			end else if (r < 85) begin
				// reload, usually a live slot in the middle of a line
				if (n_act > 0 && $urandom_range(3, 0) != 0)
					slot = $urandom_range(n_act - 1, 0);
				else
					slot = $urandom_range(NUM_PROG - 1, 0);
				push_random_load(slot);
				made++;
			end else if (r < 92) begin
				push_ignored();
			end else begin
				push_start(random_cut(), 1'($urandom_range(1, 0)));
				made++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: nothing active, so every tick scores zero
		push_tick();
		push_tick();
		push_ignored();
		push_start(16'd0, 1'b1);
		push_tick();

		// zero step, start and root at or above the step, saturation, top slot
		set_config(4, 40, 0, 0);
		push_load(0, 8'd0, 8'd0, 8'd0, 16'hFFFF);
		push_load(1, 8'd7, 8'd9, 8'd200, 16'd3);
		push_load(2, 8'd199, 8'd198, 8'd198, 16'd1);
		push_load(3, 8'd255, 8'd255, 8'd255, 16'h8000);
		push_load(NUM_PROG - 1, 8'd1, 8'd0, 8'd0, 16'd5);
		// ticks straight after the loads, no start-line beat
		repeat (3) push_tick();
		push_start(16'd0, 1'b1);
		repeat (3) push_tick();
		push_start(16'hFFFF, 1'b1);
		repeat (2) push_tick();
		push_start(16'd1, 1'b0);
		repeat (2) push_tick();
		push_ignored();

		// line length zero, current position already past the end
		set_config(4, 0, 0, 0);
		push_tick();
		push_tick();

		run_phase(8, 0, 0, 0, 16, 0);
		run_phase(12, 17, 87, 0, 16, 0);
		run_phase(30, 9, 0, 87, 16, 0);
		run_phase(20, 1, 16, 16, 12, 0);
		// receiver holds off while the rest of the table loads, input backs up
		run_phase(64, 25, 0, 0, 20, 1);
		run_phase(5, 32'h003F_FFFF, 0, 0, 8, 0);
		run_phase(0, LINE_CAP, 87, 87, 6, 0);
		// entry count above the table size, every slot loaded first
		run_phase(32'h0000_07FF, 13, 0, 0, 16, 0);
		run_phase(NUM_PROG, 31, 16, 16, 14, 0);

		wait_idle();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog, well above the slowest legal run
	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
